>>> sv/wss_pkg.sv
// shared types, constants and codes for the windowed sample statistics block
package wss_pkg;

    localparam int WSS_SAMPLE_BITS = 32;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [15:0] BUCKET_LEN_RESET = 16'd1440;

    // register indexes on the configuration port
    localparam logic REG_BUCKET_LEN   = 1'b0;
    localparam logic REG_COUNTER_MODE = 1'b1;

    // operations of the shared arithmetic unit
    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               end_of_range;
    } item_t;

    typedef struct packed {
        logic signed [31:0] mean_value;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic signed [63:0] spread;
        logic               range_done;
    } result_t;

    // sequencer to accumulator
    typedef struct packed {
        logic take;
        logic square;
        logic accumulate;
        logic clear;
    } acc_ctrl_t;

    // accumulator to sequencer
    typedef struct packed {
        logic [63:0]        sum;
        logic [63:0]        sum_sq;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic [15:0]        count;
        logic               last;
        logic               close;
    } acc_stat_t;

    // sequencer to shared arithmetic unit
    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] x;
        logic [63:0] y;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } unit_rsp_t;

endpackage

>>> sv/wss_accum.sv
// per-sample value forming, squaring and bucket accumulation
module wss_accum
    import wss_pkg::*;
#(
    parameter int SAMPLE_BITS = WSS_SAMPLE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  acc_ctrl_t   ctrl,
    input  item_t       item,
    input  logic        counter_mode,
    input  logic [15:0] bucket_len,
    output acc_stat_t   stat
);

    localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0]          raw;
    logic signed [SAMPLE_BITS-1:0]   value_next;
    logic signed [SAMPLE_BITS-1:0]   value_reg;
    logic signed [2*SAMPLE_BITS-1:0] sq_next;
    logic signed [2*SAMPLE_BITS-1:0] sq_reg;

    logic [SAMPLE_BITS-1:0]        prev_reg;
    logic                          seen_first_reg;
    logic                          last_reg;
    logic [63:0]                   sum_reg;
    logic [63:0]                   sum_sq_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic [15:0]                   count_reg;
    logic [15:0]                   count_next;
    logic [15:0]                   len_eff;

    assign raw        = item.sample[SAMPLE_BITS-1:0];
    assign value_next = (counter_mode && seen_first_reg) ? SAMPLE_BITS'(raw - prev_reg) : raw;
    assign sq_next    = value_reg * value_reg;
    assign count_next = count_reg + 16'((count_reg != 16'hFFFF) ? 1 : 0);
    assign len_eff    = (bucket_len == 16'd0) ? 16'd1 : bucket_len;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            value_reg <= value_next;
        end
        if (ctrl.square)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            seen_first_reg <= 1'b0;
            last_reg       <= 1'b0;
            sum_reg        <= '0;
            sum_sq_reg     <= '0;
            min_reg        <= VAL_MAX;
            max_reg        <= VAL_MIN;
            count_reg      <= '0;
        end
        else
        begin
            if (ctrl.take)
            begin
                prev_reg       <= raw;
                seen_first_reg <= !item.end_of_range;
                last_reg       <= item.end_of_range;
            end
            if (ctrl.clear)
            begin
                sum_reg    <= '0;
                sum_sq_reg <= '0;
                min_reg    <= VAL_MAX;
                max_reg    <= VAL_MIN;
                count_reg  <= '0;
            end
            else if (ctrl.accumulate)
            begin
                sum_reg    <= sum_reg + 64'(value_reg);
                sum_sq_reg <= sum_sq_reg + 64'($unsigned(sq_reg));
                if (value_reg < min_reg)
                begin
                    min_reg <= value_reg;
                end
                if (value_reg > max_reg)
                begin
                    max_reg <= value_reg;
                end
                count_reg <= count_next;
            end
        end
    end

    always_comb
    begin
        stat.sum       = sum_reg;
        stat.sum_sq    = sum_sq_reg;
        stat.min_value = 32'(min_reg);
        stat.max_value = 32'(max_reg);
        stat.count     = count_reg;
        stat.last      = last_reg;
        // decided while the value is being added, so it looks at the new count
        stat.close     = last_reg || (count_next >= len_eff);
    end

endmodule

>>> sv/wss_arith.sv
// shared 64-bit add/subtract unit sequenced as a shift-add multiplier or restoring divider
module wss_arith
    import wss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    localparam int DIV_STEPS = 64;
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_PREP = 2'd1;
    localparam logic [1:0] U_RUN  = 2'd2;
    localparam logic [1:0] U_FIX  = 2'd3;

    logic [1:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic             op_reg;
    logic             neg_reg;
    logic [63:0]      x_reg;
    logic [63:0]      y_reg;
    logic [63:0]      acc_reg;
    logic [63:0]      res_reg;

    logic [63:0] add_a;
    logic [63:0] add_b;
    logic        add_sub;
    logic [64:0] add_out;
    logic        carry;
    logic [63:0] rem_sh;
    logic        last_step;

    assign rem_sh    = {acc_reg[62:0], x_reg[63]};
    assign last_step = (op_reg == OP_DIV) ? (cnt_reg == CNT_W'(DIV_STEPS - 1))
                                          : (cnt_reg == CNT_W'(MUL_STEPS - 1));

    always_comb
    begin
        add_a   = acc_reg;
        add_b   = y_reg;
        add_sub = 1'b0;
        case (state_reg)
            U_PREP:
            begin
                add_a   = '0;
                add_b   = x_reg;
                add_sub = 1'b1;
            end
            U_RUN:
            begin
                if (op_reg == OP_DIV)
                begin
                    add_a   = rem_sh;
                    add_sub = 1'b1;
                end
            end
            U_FIX:
            begin
                add_a   = '0;
                add_b   = (op_reg == OP_DIV) ? x_reg : acc_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_a = acc_reg;
            end
        endcase
    end

    assign add_out = {1'b0, add_a} + {1'b0, add_b ^ {64{add_sub}}} + 65'(add_sub);
    // no borrow on a subtract
    assign carry   = add_out[64];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_reg  <= req.op;
                    neg_reg <= req.x[63];
                    x_reg   <= req.x;
                    y_reg   <= req.y;
                    acc_reg <= '0;
                end
            end
            U_PREP:
            begin
                if (neg_reg)
                begin
                    x_reg <= add_out[63:0];
                end
            end
            U_RUN:
            begin
                if (op_reg == OP_DIV)
                begin
                    x_reg   <= {x_reg[62:0], carry};
                    acc_reg <= carry ? add_out[63:0] : rem_sh;
                end
                else
                begin
                    if (x_reg[0])
                    begin
                        acc_reg <= add_out[63:0];
                    end
                    x_reg <= {1'b0, x_reg[63:1]};
                    y_reg <= {y_reg[62:0], 1'b0};
                end
            end
            U_FIX:
            begin
                res_reg <= neg_reg ? add_out[63:0] : ((op_reg == OP_DIV) ? x_reg : acc_reg);
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    cnt_reg <= '0;
                    if (req.start)
                    begin
                        state_reg <= U_PREP;
                    end
                end
                U_PREP:
                begin
                    state_reg <= U_RUN;
                end
                U_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_step)
                    begin
                        state_reg <= U_FIX;
                    end
                end
                U_FIX:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == U_IDLE)
        else $error("arith unit started while busy");

    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == U_FIX && state_reg == U_IDLE)
        else $error("arith done without a fix step");

    a_mul_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_RUN && op_reg == OP_MUL) |-> cnt_reg < CNT_W'(MUL_STEPS))
        else $error("multiply ran past its step count");

endmodule

>>> sv/windowed_sample_statistics.sv
// windowed sample statistics top level: configuration, sequencer and result register
// Each sample word goes through accept, square and accumulate steps when it does not close
// a bucket. A word that closes a bucket (count reaches bucket_len, or end_of_range) adds
// the close sequence on the shared 64-bit add/subtract unit: a 64-step divide for the
// mean, and for buckets of two or more values a 32-step multiply and a second 64-step
// divide for the spread, each with a setup and a sign-fix step. The result word sits in
// an output register, so the next sample is taken while it waits; only a second close
// with the register still full holds the block.
module windowed_sample_statistics
    import wss_pkg::*;
#(
    parameter int SAMPLE_BITS = WSS_SAMPLE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  item_t                    item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_t                  result
);

    localparam logic [3:0] T_IDLE   = 4'd0;
    localparam logic [3:0] T_SQ     = 4'd1;
    localparam logic [3:0] T_ACC    = 4'd2;
    localparam logic [3:0] T_MEAN   = 4'd3;
    localparam logic [3:0] T_MEAN_W = 4'd4;
    localparam logic [3:0] T_MUL    = 4'd5;
    localparam logic [3:0] T_MUL_W  = 4'd6;
    localparam logic [3:0] T_DIV    = 4'd7;
    localparam logic [3:0] T_DIV_W  = 4'd8;
    localparam logic [3:0] T_OUT    = 4'd9;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [15:0] bucket_len_reg;
    logic        counter_mode_reg;
    logic        result_valid_reg;
    result_t     result_reg;
    logic [31:0] mean_reg;
    logic [63:0] spread_reg;
    logic [63:0] diff_reg;

    logic       item_take;
    logic       out_free;
    acc_ctrl_t  ctrl;
    acc_stat_t  stat;
    unit_req_t  req;
    unit_rsp_t  rsp;

    assign item_stall = (state_reg != T_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    always_comb
    begin
        ctrl.take       = item_take;
        ctrl.square     = (state_reg == T_SQ);
        ctrl.accumulate = (state_reg == T_ACC);
        ctrl.clear      = (state_reg == T_OUT) && out_free;
    end

    wss_accum #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .item         (item),
        .counter_mode (counter_mode_reg),
        .bucket_len   (bucket_len_reg),
        .stat         (stat)
    );

    always_comb
    begin
        req.start = 1'b0;
        req.op    = OP_DIV;
        req.x     = stat.sum;
        req.y     = {48'd0, stat.count};
        case (state_reg)
            T_MEAN:
            begin
                req.start = 1'b1;
            end
            T_MUL:
            begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.x     = 64'($signed(mean_reg));
                req.y     = stat.sum;
            end
            T_DIV:
            begin
                req.start = 1'b1;
                req.x     = diff_reg;
                req.y     = {48'd0, stat.count - 16'd1};
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    wss_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (item_take)
                begin
                    state_next = T_SQ;
                end
            end
            T_SQ:
            begin
                state_next = T_ACC;
            end
            T_ACC:
            begin
                state_next = stat.close ? T_MEAN : T_IDLE;
            end
            T_MEAN:
            begin
                state_next = T_MEAN_W;
            end
            T_MEAN_W:
            begin
                if (rsp.done)
                begin
                    // a single value has no spread
                    state_next = (stat.count == 16'd1) ? T_OUT : T_MUL;
                end
            end
            T_MUL:
            begin
                state_next = T_MUL_W;
            end
            T_MUL_W:
            begin
                if (rsp.done)
                begin
                    state_next = T_DIV;
                end
            end
            T_DIV:
            begin
                state_next = T_DIV_W;
            end
            T_DIV_W:
            begin
                if (rsp.done)
                begin
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // close-sequence payload
    always_ff @(posedge clk)
    begin
        if (state_reg == T_MEAN_W && rsp.done)
        begin
            mean_reg   <= rsp.result[31:0];
            spread_reg <= '0;
        end
        if (state_reg == T_MUL_W && rsp.done)
        begin
            diff_reg <= stat.sum_sq - rsp.result;
        end
        if (state_reg == T_DIV_W && rsp.done)
        begin
            spread_reg <= rsp.result;
        end
        if (state_reg == T_OUT && out_free)
        begin
            result_reg.mean_value <= $signed(mean_reg);
            result_reg.min_value  <= stat.min_value;
            result_reg.max_value  <= stat.max_value;
            result_reg.spread     <= $signed(spread_reg);
            result_reg.range_done <= stat.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            bucket_len_reg   <= BUCKET_LEN_RESET;
            counter_mode_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BUCKET_LEN:
                    begin
                        bucket_len_reg <= cfg_data[15:0];
                    end
                    REG_COUNTER_MODE:
                    begin
                        counter_mode_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        counter_mode_reg <= counter_mode_reg;
                    end
                endcase
            end
            if (state_reg == T_OUT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_take_goes_to_square: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> state_reg == T_SQ)
        else $error("accepted word did not start the square step");

    a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_MEAN |-> stat.count != 16'd0)
        else $error("bucket closed with no values");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == T_MEAN_W || state_reg == T_MUL_W || state_reg == T_DIV_W))
        else $error("arith result arrived outside a wait state");

    a_single_no_spread: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_MEAN_W && rsp.done && stat.count == 16'd1) |=> state_reg == T_OUT)
        else $error("single-value bucket entered the spread sequence");

endmodule
